// ===== sv/dotl_pkg.sv =====
// dotl_pkg: shared constants and types for the dhcp option tlv locator
// no dependencies; imported by the top level and the port checker

package dotl_pkg;

  localparam int OFFSET_BITS = 11;
  localparam int STOP_BITS   = OFFSET_BITS + 1;

  localparam logic [7:0] END_CODE = 8'd255;
  localparam logic [7:0] PAD_CODE = 8'd0;

  // configuration register indexes
  localparam logic [1:0] CFG_TARGET_CODE    = 2'd0;
  localparam logic [1:0] CFG_SCAN_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_SUBOPTION_MODE = 2'd2;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_SKIPLEN = 2'd1,
    PH_FIT     = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

endpackage

// ===== sv/dhcp_option_tlv_locator_unit.sv =====
// dhcp_option_tlv_locator_unit: walks the tlv chain of a dhcp options area
// and gives one status transaction per packet; depends on dotl_pkg
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid in_stall in_data_byte         | byte in
//           | in_last_byte                           |
//   out     | out_valid out_stall out_status         | result out
//           | out_found_offset                       |
//   cfg     | cfg_we cfg_index cfg_wdata             | write only
//
// one byte is taken per cycle while in_stall is low; its compare and add run in the same cycle
// and any result is registered in the output register, or in the skid register if the output is held
// a two-entry output (output register plus skid register) lets bytes keep
// flowing while a result waits; in_stall rises only when both are full
// rst_n is synchronous, active low; clears walk state, config and valids
// out_stall holds the result in place; nothing is dropped or repeated

module dhcp_option_tlv_locator_unit
  import dotl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // byte channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_last_byte,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [OFFSET_BITS-1:0] out_found_offset,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [OFFSET_BITS-1:0] cfg_wdata
);

  // configuration registers
  logic [7:0]             target_code_r;
  logic [OFFSET_BITS-1:0] scan_limit_r;
  logic                   suboption_mode_r;

  // per-packet walk state
  logic [OFFSET_BITS-1:0] byte_position_r, byte_position_nxt;
  logic [STOP_BITS-1:0]   next_stop_r, next_stop_nxt;
  phase_t                 phase_r, phase_nxt;
  logic                   stop_is_target_r, stop_is_target_nxt;
  logic [OFFSET_BITS-1:0] stop_offset_r, stop_offset_nxt;

  // output register and skid register
  logic                   out_valid_r;
  status_t                out_status_r;
  logic [OFFSET_BITS-1:0] out_offset_r;
  logic                   skid_valid_r;
  status_t                skid_status_r;
  logic [OFFSET_BITS-1:0] skid_offset_r;

  logic                   in_take;
  logic                   out_pop;

  // per-byte decision terms
  logic                   at_stop;
  logic                   is_target;
  logic                   keep_walking;
  logic                   limit_bad;
  logic [STOP_BITS-1:0]   limit_ext;
  logic [STOP_BITS-1:0]   skip_sum;
  logic [STOP_BITS-1:0]   fit_sum;

  // result of the current byte
  logic                   res_valid;
  status_t                res_status;
  logic [OFFSET_BITS-1:0] res_offset;

  assign in_take = in_valid && !in_stall;
  assign out_pop = out_valid_r && !out_stall;

  assign limit_ext    = {1'b0, scan_limit_r};
  assign at_stop      = ({1'b0, byte_position_r} == next_stop_r);
  assign is_target    = (in_data_byte == target_code_r);
  // an ordinary option or pad inside the limit: the walk goes on
  assign keep_walking = (next_stop_r < limit_ext) && (in_data_byte != END_CODE) && !is_target;
  // walk reached the limit without the end code
  assign limit_bad    = (next_stop_r == limit_ext) && (in_data_byte != END_CODE);
  // next code offset after a skip: code, length byte, then the value
  assign skip_sum     = next_stop_r + STOP_BITS'(2) + STOP_BITS'(in_data_byte);
  // length-fit test: the stop option must end before the limit
  assign fit_sum      = {1'b0, stop_offset_r} + STOP_BITS'(2) + STOP_BITS'(in_data_byte);

  // result of the accepted byte
  always_comb begin
    res_valid  = 1'b0;
    res_status = ST_NONE;
    res_offset = '0;
    unique case (phase_r)
      PH_SEARCH: begin
        if (at_stop && !keep_walking) begin
          if (limit_bad) begin
            res_valid  = 1'b1;
            res_status = ST_BAD;
          end else if (suboption_mode_r) begin
            res_valid = 1'b1;
            if (is_target) begin
              res_status = ST_FOUND;
              res_offset = next_stop_r[OFFSET_BITS-1:0];
            end
          end
        end
      end
      PH_SKIPLEN: begin
        if (skip_sum > limit_ext) begin
          res_valid  = 1'b1;
          res_status = ST_BAD;
        end
      end
      PH_FIT: begin
        res_valid = 1'b1;
        if (fit_sum >= limit_ext) begin
          res_status = ST_BAD;
        end else if (stop_is_target_r) begin
          res_status = ST_FOUND;
          res_offset = stop_offset_r;
        end
      end
      PH_DONE: begin
        res_valid = 1'b0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    // packet ended before any decision
    if (in_last_byte && !res_valid && (phase_r != PH_DONE)) begin
      res_valid  = 1'b1;
      res_status = ST_BAD;
      res_offset = '0;
    end
  end

  // next walk state
  always_comb begin
    byte_position_nxt  = byte_position_r + OFFSET_BITS'(1);
    next_stop_nxt      = next_stop_r;
    phase_nxt          = phase_r;
    stop_is_target_nxt = stop_is_target_r;
    stop_offset_nxt    = stop_offset_r;
    unique case (phase_r)
      PH_SEARCH: begin
        if (at_stop) begin
          if (keep_walking) begin
            if (in_data_byte == PAD_CODE) begin
              next_stop_nxt = next_stop_r + STOP_BITS'(1);
            end else begin
              phase_nxt = PH_SKIPLEN;
            end
          end else if (limit_bad || suboption_mode_r) begin
            phase_nxt = PH_DONE;
          end else begin
            stop_is_target_nxt = is_target;
            stop_offset_nxt    = next_stop_r[OFFSET_BITS-1:0];
            phase_nxt          = PH_FIT;
          end
        end
      end
      PH_SKIPLEN: begin
        next_stop_nxt = skip_sum;
        phase_nxt     = (skip_sum > limit_ext) ? PH_DONE : PH_SEARCH;
      end
      PH_FIT: begin
        phase_nxt = PH_DONE;
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_SEARCH;
      end
    endcase
    // packet end: walk state back to its start
    if (in_last_byte) begin
      byte_position_nxt  = '0;
      next_stop_nxt      = '0;
      phase_nxt          = PH_SEARCH;
      stop_is_target_nxt = 1'b0;
      stop_offset_nxt    = '0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_code_r    <= '0;
      scan_limit_r     <= '0;
      suboption_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_CODE:    target_code_r    <= cfg_wdata[7:0];
        CFG_SCAN_LIMIT:     scan_limit_r     <= cfg_wdata;
        CFG_SUBOPTION_MODE: suboption_mode_r <= cfg_wdata[0];
        default: begin
          target_code_r <= target_code_r;
        end
      endcase
    end
  end

  // walk state update, one byte per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r  <= '0;
      next_stop_r      <= '0;
      phase_r          <= PH_SEARCH;
      stop_is_target_r <= 1'b0;
      stop_offset_r    <= '0;
    end else if (in_take) begin
      byte_position_r  <= byte_position_nxt;
      next_stop_r      <= next_stop_nxt;
      phase_r          <= phase_nxt;
      stop_is_target_r <= stop_is_target_nxt;
      stop_offset_r    <= stop_offset_nxt;
    end
  end

  // output register with skid: skid fills only when output is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_take && res_valid) begin
      if (!out_valid_r || out_pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_status_r <= skid_status_r;
        out_offset_r <= skid_offset_r;
      end
    end else if (in_take && res_valid) begin
      if (!out_valid_r || out_pop) begin
        out_status_r <= res_status;
        out_offset_r <= res_offset;
      end else begin
        skid_status_r <= res_status;
        skid_offset_r <= res_offset;
      end
    end
  end

  assign in_stall         = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_offset = out_offset_r;

endmodule

// ===== sv/dotl_checker.sv =====
// dotl_checker: port-level checks on the dhcp option tlv locator
// depends on dotl_pkg; bound to dhcp_option_tlv_locator_unit below

module dotl_checker
  import dotl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [1:0]             out_status,
  input logic [OFFSET_BITS-1:0] out_found_offset
);

  // result never uses the unused status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_FOUND || out_status == ST_NONE || out_status == ST_BAD))
    else $error("status code out of range");

  // offset only carries meaning on a found result
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_FOUND) |-> (out_found_offset == '0))
    else $error("offset set on a non-found result");

  // input backpressure only while a result is waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) && $stable(out_found_offset)))
    else $error("stalled result changed");

endmodule

bind dhcp_option_tlv_locator_unit dotl_checker u_dotl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_found_offset (out_found_offset)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for dhcp_option_tlv_locator_unit, with an inline walk predictor
// needs dotl_pkg and dhcp_option_tlv_locator_unit; directed packets, then random option chains

module tb_top;
  import dotl_pkg::*;

  // option codes used as plain data in the directed packets
  localparam logic [7:0] MSG_TYPE_CODE  = 8'd53;
  localparam logic [7:0] HOST_NAME_CODE = 8'd12;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } option_byte_t;

  typedef struct {
    status_t                status;
    logic [OFFSET_BITS-1:0] offset;
  } locate_result_t;

  logic clk;
  logic rst_n = 1'b0;

  // byte channel
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_data_byte = '0;
  logic                   in_last_byte = 1'b0;
  // result channel
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic [1:0]             out_status;
  logic [OFFSET_BITS-1:0] out_found_offset;
  // register writes
  logic                   cfg_we       = 1'b0;
  logic [1:0]             cfg_index    = '0;
  logic [OFFSET_BITS-1:0] cfg_wdata    = '0;

  dhcp_option_tlv_locator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found_offset (out_found_offset),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // stimulus side: bytes waiting to go out and how many were queued / taken
  option_byte_t   bytes_to_send[$];
  locate_result_t results_due[$];
  int unsigned    bytes_queued = 0;
  int unsigned    bytes_taken  = 0;
  int unsigned    mismatches   = 0;

  // idle rates in percent, and the long receiver hold-off request
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;

  // target the generator builds packets around
  logic [7:0]             cur_tgt;

  // predictor copy of the registers, tracked from the write port
  logic [7:0]             tgt_cfg = '0;
  logic [OFFSET_BITS-1:0] lim_cfg = '0;
  logic                   sub_cfg = 1'b0;

  // predictor copy of the walk state
  logic [OFFSET_BITS-1:0] walk_pos  = '0;
  logic [STOP_BITS-1:0]   code_at   = '0;  // offset of the next code byte of the chain
  phase_t                 walk_phase = PH_SEARCH;
  logic                   stop_hit  = 1'b0;
  logic [OFFSET_BITS-1:0] stop_ofs  = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic locate_result_t tlv_result(status_t st, logic [OFFSET_BITS-1:0] ofs);
    locate_result_t r;
    r.status = st;
    r.offset = (st == ST_FOUND) ? ofs : '0;
    return r;
  endfunction

  // one accepted byte through the chain walk; pushes the packet's result when decided
  task automatic step_tlv_walk(input logic [7:0] b, input logic last);
    locate_result_t r;
    bit             decided;
    decided = 0;
    case (walk_phase)
      PH_SEARCH: begin
        if ({1'b0, walk_pos} == code_at) begin
          if (code_at < lim_cfg && b != END_CODE && b != tgt_cfg) begin
            // pad moves one byte, any other code waits for its length
            if (b == PAD_CODE) code_at = code_at + STOP_BITS'(1);
            else walk_phase = PH_SKIPLEN;
          end else if (code_at == lim_cfg && b != END_CODE) begin
            // walk hit the limit without an end code
            r = tlv_result(ST_BAD, '0);
            decided = 1;
          end else if (sub_cfg) begin
            r = tlv_result((b == tgt_cfg) ? ST_FOUND : ST_NONE, code_at[OFFSET_BITS-1:0]);
            decided = 1;
          end else begin
            stop_hit   = (b == tgt_cfg);
            stop_ofs   = code_at[OFFSET_BITS-1:0];
            walk_phase = PH_FIT;
          end
        end
      end
      PH_SKIPLEN: begin
        code_at = code_at + STOP_BITS'(2) + STOP_BITS'(b);
        if (code_at > lim_cfg) begin
          // jump lands past the scan limit
          r = tlv_result(ST_BAD, '0);
          decided = 1;
        end else begin
          walk_phase = PH_SEARCH;
        end
      end
      PH_FIT: begin
        // length byte after the stop must keep the option inside the area
        if (stop_ofs + 2 + b >= lim_cfg) r = tlv_result(ST_BAD, '0);
        else r = tlv_result(stop_hit ? ST_FOUND : ST_NONE, stop_ofs);
        decided = 1;
      end
      default: ;
    endcase
    if (decided) begin
      walk_phase = PH_DONE;
      results_due.push_back(r);
    end
    walk_pos = walk_pos + OFFSET_BITS'(1);
    if (last) begin
      // packet ended before any decision
      if (!decided && walk_phase != PH_DONE) results_due.push_back(tlv_result(ST_BAD, '0));
      walk_pos   = '0;
      code_at    = '0;
      walk_phase = PH_SEARCH;
      stop_hit   = 1'b0;
      stop_ofs   = '0;
    end
  endtask

  // driver: a new byte goes out only once the previous transaction was taken
  always @(posedge clk) begin : byte_driver
    option_byte_t nb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (bytes_to_send.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        nb = bytes_to_send.pop_front();
        in_valid     <= 1'b1;
        in_data_byte <= nb.data;
        in_last_byte <= nb.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or a long hold-off counted here
  always @(posedge clk) begin : result_receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // register writes and accepted bytes feed the predictor
  always @(posedge clk) begin : walk_tracker
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_CODE:    tgt_cfg = cfg_wdata[7:0];
          CFG_SCAN_LIMIT:     lim_cfg = cfg_wdata;
          CFG_SUBOPTION_MODE: sub_cfg = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        step_tlv_walk(in_data_byte, in_last_byte);
        bytes_taken = bytes_taken + 1;
      end
    end
  end

  // every result transaction is matched against the oldest prediction
  always @(posedge clk) begin : result_checker
    locate_result_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result with none due: out_status %0d out_found_offset %0d",
               out_status, out_found_offset);
        mismatches = mismatches + 1;
      end else begin
        due = results_due.pop_front();
        if (out_status != due.status) begin
          $error("out_status expected %0d actual %0d", due.status, out_status);
          mismatches = mismatches + 1;
        end
        if (out_found_offset != due.offset) begin
          $error("out_found_offset expected %0d actual %0d", due.offset, out_found_offset);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  task automatic put_byte(input logic [7:0] data, input logic last);
    option_byte_t nb;
    nb.data = data;
    nb.last = last;
    bytes_to_send.push_back(nb);
    bytes_queued = bytes_queued + 1;
  endtask

  task automatic put_packet(input logic [7:0] pkt[$]);
    for (int k = 0; k < pkt.size(); k++) put_byte(pkt[k], k == pkt.size() - 1);
  endtask

  // sender holds back until every byte is taken and every result is in
  task automatic wait_idle();
    while (bytes_taken != bytes_queued || results_due.size() != 0) @(posedge clk);
    // a byte with no result may still be in the block
    repeat (4) @(posedge clk);
  endtask

  // all three registers, with junk in the bits each register ignores
  task automatic set_regs(input logic [7:0] tgt, input logic [OFFSET_BITS-1:0] lim,
                          input logic sub);
    logic [2:0] hi3;
    logic [9:0] hi10;
    hi3  = 3'($urandom_range(7));
    hi10 = 10'($urandom_range(1023));
    cur_tgt = tgt;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_CODE;
    cfg_wdata <= {hi3, tgt};
    @(posedge clk);
    cfg_index <= CFG_SCAN_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_index <= CFG_SUBOPTION_MODE;
    cfg_wdata <= {hi10, sub};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random packet: mostly option chains, some truncated, some plain noise
  task automatic queue_random_packet();
    logic [7:0] pkt[$];
    int         kind, len, cut;
    kind = $urandom_range(99);
    if (kind < 12) begin
      len = $urandom_range(1, 12);
      repeat (len) pkt.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(4)) begin
        if ($urandom_range(4) == 0) begin
          pkt.push_back(PAD_CODE);
        end else begin
          // rare long options reach the far end of the length byte
          len = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(4);
          pkt.push_back(8'($urandom_range(1, 254)));
          pkt.push_back(8'(len));
          repeat (len) pkt.push_back(8'($urandom_range(255)));
        end
      end
      case ($urandom_range(2))
        0: pkt.push_back(cur_tgt);
        1: pkt.push_back(END_CODE);
        default: ;
      endcase
      // byte after the stop, read by the length-fit test
      pkt.push_back(8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(6)));
      repeat ($urandom_range(2)) pkt.push_back(8'($urandom_range(255)));
      if (kind < 25) begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) pkt.pop_back();
      end
    end
    put_packet(pkt);
  endtask

  initial begin : stimulus
    logic [7:0]             tgt;
    logic [OFFSET_BITS-1:0] lim;
    int unsigned            block_start;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 23;
    rcv_idle_pct = 63;

    // directed: normal find, not found, jump past limit, early end, fit failure
    set_regs(MSG_TYPE_CODE, 11'd20, 1'b0);
    put_byte(PAD_CODE, 0);
    put_byte(MSG_TYPE_CODE, 0);
    put_byte(8'd1, 0);
    put_byte(8'd5, 0);
    put_byte(END_CODE, 1);
    put_byte(HOST_NAME_CODE, 0);
    put_byte(8'd2, 0);
    put_byte(8'h5a, 0);
    put_byte(8'ha5, 0);
    put_byte(END_CODE, 0);
    put_byte(PAD_CODE, 1);
    put_byte(HOST_NAME_CODE, 0);
    put_byte(8'd250, 1);
    put_byte(MSG_TYPE_CODE, 1);
    put_byte(MSG_TYPE_CODE, 0);
    put_byte(8'd200, 1);
    wait_idle();

    // zero limit: end code right at the limit versus any other byte
    set_regs(END_CODE, 11'd0, 1'b1);
    put_byte(END_CODE, 1);
    put_byte(PAD_CODE, 1);
    wait_idle();

    // pad as target with the widest limit
    set_regs(PAD_CODE, 11'd2047, 1'b1);
    put_byte(PAD_CODE, 1);
    put_byte(8'hff, 1);
    wait_idle();

    // walk reaches the limit on a code that is not the end code
    set_regs(END_CODE, 11'd2, 1'b1);
    put_byte(PAD_CODE, 0);
    put_byte(PAD_CODE, 0);
    put_byte(8'd7, 1);
    wait_idle();

    // random part in blocks, registers changed between blocks
    for (int blk = 0; blk < 24; blk++) begin
      if (blk == 8) begin
        snd_idle_pct = 63;
        rcv_idle_pct = 23;
      end else if (blk == 16) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case ($urandom_range(5))
        0: lim = 11'd0;
        1: lim = 11'd2047;
        2: lim = 11'($urandom_range(2047));
        default: lim = 11'($urandom_range(1, 40));
      endcase
      case ($urandom_range(4))
        0: tgt = PAD_CODE;
        1: tgt = END_CODE;
        default: tgt = 8'($urandom_range(255));
      endcase
      set_regs(tgt, lim, 1'($urandom_range(1)));
      block_start = bytes_queued;
      if (blk == 20) begin
        // receiver holds off while short packets pile up and back-pressure the input
        hold_request = 120;
        repeat (40) put_byte(8'($urandom_range(255)), 1'b1);
      end else begin
        while (bytes_queued - block_start < 50) queue_random_packet();
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d results still due at end of run", results_due.size());
      mismatches = mismatches + 1;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== dhcp_option_tlv_locator_unit.f =====
sv/dotl_pkg.sv
sv/dhcp_option_tlv_locator_unit.sv
sv/dotl_checker.sv
sim/tb_top.sv
